// File: src/cbz_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbz_pkg
// Shared constants, types and the interpolation function for the cubic
// Bezier point and tangent evaluator.
// ----------------------------------------------------------------------------
package cbz_pkg;

  localparam int CW     = 20;          // coordinate width, signed Q12.8
  localparam int TF     = 16;          // fraction bits of t
  localparam int TW     = TF + 1;      // width of t including the one
  localparam int DW     = 16;          // direction component width, Q1.14
  localparam int MAG_W  = 24;          // normalised magnitude width
  localparam int SUM_W  = 2 * MAG_W + 2;
  localparam int SQ_W   = 52;          // root extraction word, even pairs
  localparam int NSQ    = SQ_W / 2;    // root cells, one result bit each
  localparam int L_W    = NSQ - 1;     // width of the root
  localparam int Q_W    = 15;          // quotient bits
  localparam int DV_W   = MAG_W + Q_W; // remainder and divisor width
  localparam int ND     = Q_W;         // divider cells per lane

  // pipeline stage numbers
  localparam int ST_SQ0  = 9;
  localparam int ST_DP   = ST_SQ0 + NSQ;
  localparam int ST_LAST = ST_DP + ND;
  localparam int NST     = ST_LAST + 1;

  localparam logic [TW-1:0] T_ONE  = TW'(1) << TF;
  localparam logic [TW-1:0] NEAR_T = TW'(((64'd999 << TF) + 64'd500) / 64'd1000);
  localparam logic [Q_W-1:0] DIR_ONE = Q_W'(16384);

  // configuration register indexes
  localparam logic [2:0] CFG_CP0 = 3'd0;
  localparam logic [2:0] CFG_CP1 = 3'd1;
  localparam logic [2:0] CFG_CP2 = 3'd2;
  localparam logic [2:0] CFG_CP3 = 3'd3;

  typedef logic signed [CW-1:0] crd_t;

  typedef struct packed {
    logic [SQ_W-1:0] n;
    logic [SQ_W-1:0] res;
    logic [SQ_W-1:0] bitv;
  } sq_t;

  typedef struct packed {
    logic [DV_W-1:0] rem;
    logic [DV_W-1:0] dsor;
    logic [Q_W-1:0]  quo;
  } dv_t;

  typedef struct packed {
    logic [3*CW-1:0]    pos;
    logic [2:0]         neg;
    logic               dv;
    logic [3*MAG_W-1:0] mag;
  } side_t;

  // a + round((b - a) * t), floor of the rounded product
  function automatic crd_t lerp(input crd_t a, input crd_t b, input logic [TW-1:0] t);
    logic signed [CW:0]      d;
    logic signed [CW+TW+1:0] p;
    d = $signed({b[CW-1], b}) - $signed({a[CW-1], a});
    p = $signed({{(TW+1){d[CW]}}, d}) * $signed({{(CW+2){1'b0}}, t});
    p = p + $signed({{(CW+TW+2-TF){1'b0}}, 1'b1, {(TF-1){1'b0}}});
    lerp = a + CW'(p >>> TF);
  endfunction

endpackage
`default_nettype wire

// File: src/cbz_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbz_sqrt_cell
// One step of restoring integer square root: settles one result bit and
// hands the remainder, partial root and trial bit to the next cell.
// ----------------------------------------------------------------------------
module cbz_sqrt_cell (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  cbz_pkg::sq_t      sq_i,
  output cbz_pkg::sq_t      sq_o
);
  import cbz_pkg::*;

  sq_t             sq_d, sq_q;
  logic [SQ_W-1:0] trial;

  // try to subtract the trial value
  always_comb begin
    trial   = sq_i.res + sq_i.bitv;
    sq_d    = sq_i;
    sq_d.bitv = sq_i.bitv >> 2;
    if (sq_i.n >= trial) begin
      sq_d.n   = sq_i.n - trial;
      sq_d.res = (sq_i.res >> 1) + sq_i.bitv;
    end else begin
      sq_d.res = sq_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule
`default_nettype wire

// File: src/cbz_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbz_div_cell
// One step of restoring division: settles one quotient bit and hands the
// remainder and the halved divisor to the next cell.
// ----------------------------------------------------------------------------
module cbz_div_cell (
  input  wire logic    clk_i,
  input  wire logic    en_i,
  input  cbz_pkg::dv_t dv_i,
  output cbz_pkg::dv_t dv_o
);
  import cbz_pkg::*;

  dv_t  dv_d, dv_q;
  logic ge;

  // compare, subtract and shift in the quotient bit
  always_comb begin
    ge        = dv_i.rem >= dv_i.dsor;
    dv_d.rem  = ge ? (dv_i.rem - dv_i.dsor) : dv_i.rem;
    dv_d.dsor = dv_i.dsor >> 1;
    dv_d.quo  = {dv_i.quo[Q_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q <= dv_d;
    end
  end

  assign dv_o = dv_q;

endmodule
`default_nettype wire

// File: src/cubic_bezier_point_and_tangent.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bezier_point_and_tangent
// Item path: pipeline stages 0 to 50 from the accepting edge, then the
// output register on which the result appears.
// Throughput: one item per cycle while the skid register is empty; the root
// chain (26 cells) and the divider chains (15 cells per lane) settle one bit per cell.
// Reset clears the control points, the stage valid bits and the output and
// skid valid flags; the block accepts items from the first cycle after reset.
// ----------------------------------------------------------------------------
module cubic_bezier_point_and_tangent (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [59:0]  cfg_data_i,
  input  wire logic         s_axis_tvalid_i,
  output      logic         s_axis_tready_o,
  input  wire logic [23:0]  s_axis_tdata_i,   // t_param[16:0], zero pad
  output      logic         m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, zero pad
  output      logic [111:0] m_axis_tdata_o,
  output      logic         m_axis_tuser_o    // dir_valid
);
  import cbz_pkg::*;

  typedef struct packed {
    logic [3*CW-1:0] pos;
    logic [3*DW-1:0] dir;
    logic            dv;
  } res_t;

  logic [3*CW-1:0] cp_q [4];
  logic [NST-1:0]  v_q;
  logic            en;

  // control point registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) cp_q[i] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CP0: cp_q[0] <= cfg_data_i;
        CFG_CP1: cp_q[1] <= cfg_data_i;
        CFG_CP2: cp_q[2] <= cfg_data_i;
        CFG_CP3: cp_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage valid bits, whole pipe advances while the skid is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], s_axis_tvalid_i};
    end
  end

  // ---------------- front datapath ----------------
  logic [TW-1:0] t_in;
  logic [TW-1:0] t0_q, t1_q, t2_q;
  crd_t a_c [4][3];
  crd_t b0_q [3], b1_q [3], b2_q [3], nr1_q [3], nr2_q [3], nr3_q [3];
  crd_t e0_q [3], e1_q [3], e1b_q [3], p3_q [3];
  crd_t p4_q [3], p5_q [3], p6_q [3], p7_q [3], p8_q [3];
  logic signed [CW:0] v4_q [3];
  logic               dv4_q, dv5_q, dv6_q, dv7_q, dv8_q;
  logic [CW:0]        mag5_q [3];
  logic [CW:0]        max5_q;
  logic [2:0]         neg5_q, neg6_q, neg7_q, neg8_q;
  logic [MAG_W-1:0]   mag6_q [3], mag7_q [3], mag8_q [3];
  logic [2*MAG_W-1:0] sq7_q [3];
  logic [SUM_W-1:0]   sum8_q;

  assign t_in = (s_axis_tdata_i[TW-1:0] > T_ONE) ? T_ONE : s_axis_tdata_i[TW-1:0];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 3; k++) a_c[i][k] = cp_q[i][k*CW +: CW];
    end
  end

  // comb helpers for selection and shift
  logic signed [CW:0] va [3], vb [3];
  logic               va_z, vb_z;
  logic [4:0]         msb;
  logic [4:0]         sh;
  logic [MAG_W+CW:0]  shw [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      va[k] = $signed({e1b_q[k][CW-1], e1b_q[k]}) - $signed({p3_q[k][CW-1], p3_q[k]});
      vb[k] = $signed({p3_q[k][CW-1], p3_q[k]}) - $signed({nr3_q[k][CW-1], nr3_q[k]});
    end
    va_z = (va[0] == '0) && (va[1] == '0) && (va[2] == '0);
    vb_z = (vb[0] == '0) && (vb[1] == '0) && (vb[2] == '0);
    msb = '0;
    for (int i = 0; i <= CW; i++) begin
      if (max5_q[i]) msb = 5'(i);
    end
    sh = 5'(MAG_W - 1) - msb;
    for (int k = 0; k < 3; k++) begin
      shw[k] = {{MAG_W{1'b0}}, mag5_q[k]} << sh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 0: hold saturated t
      t0_q <= t_in;
      // stage 1: first interpolation level and the near-end point
      t1_q <= t0_q;
      for (int k = 0; k < 3; k++) begin
        b0_q[k]  <= lerp(a_c[0][k], a_c[1][k], t0_q);
        b1_q[k]  <= lerp(a_c[1][k], a_c[2][k], t0_q);
        b2_q[k]  <= lerp(a_c[2][k], a_c[3][k], t0_q);
        nr1_q[k] <= lerp(a_c[2][k], a_c[3][k], NEAR_T);
      end
      // stage 2: second level
      t2_q <= t1_q;
      for (int k = 0; k < 3; k++) begin
        e0_q[k]  <= lerp(b0_q[k], b1_q[k], t1_q);
        e1_q[k]  <= lerp(b1_q[k], b2_q[k], t1_q);
        nr2_q[k] <= nr1_q[k];
      end
      // stage 3: curve point
      for (int k = 0; k < 3; k++) begin
        p3_q[k]  <= lerp(e0_q[k], e1_q[k], t2_q);
        e1b_q[k] <= e1_q[k];
        nr3_q[k] <= nr2_q[k];
      end
      // stage 4: pick the tangent vector
      for (int k = 0; k < 3; k++) begin
        v4_q[k] <= va_z ? vb[k] : va[k];
        p4_q[k] <= p3_q[k];
      end
      dv4_q <= !(va_z && vb_z);
      // stage 5: magnitudes, signs and largest magnitude
      for (int k = 0; k < 3; k++) begin
        mag5_q[k] <= v4_q[k][CW] ? $unsigned(-v4_q[k]) : $unsigned(v4_q[k]);
        neg5_q[k] <= v4_q[k][CW];
        p5_q[k]   <= p4_q[k];
      end
      begin
        logic [CW:0] m0, m1, m2, mm;
        m0 = v4_q[0][CW] ? $unsigned(-v4_q[0]) : $unsigned(v4_q[0]);
        m1 = v4_q[1][CW] ? $unsigned(-v4_q[1]) : $unsigned(v4_q[1]);
        m2 = v4_q[2][CW] ? $unsigned(-v4_q[2]) : $unsigned(v4_q[2]);
        mm = (m0 > m1) ? m0 : m1;
        max5_q <= (m2 > mm) ? m2 : mm;
      end
      dv5_q <= dv4_q;
      // stage 6: scale so the largest lies in [2^23, 2^24)
      for (int k = 0; k < 3; k++) begin
        mag6_q[k] <= shw[k][MAG_W-1:0];
        p6_q[k]   <= p5_q[k];
      end
      neg6_q <= neg5_q;
      dv6_q  <= dv5_q;
      // stage 7: squares
      for (int k = 0; k < 3; k++) begin
        sq7_q[k]  <= (2*MAG_W)'(mag6_q[k]) * (2*MAG_W)'(mag6_q[k]);
        mag7_q[k] <= mag6_q[k];
        p7_q[k]   <= p6_q[k];
      end
      neg7_q <= neg6_q;
      dv7_q  <= dv6_q;
      // stage 8: sum of squares
      sum8_q <= SUM_W'(sq7_q[0]) + SUM_W'(sq7_q[1]) + SUM_W'(sq7_q[2]);
      for (int k = 0; k < 3; k++) begin
        mag8_q[k] <= mag7_q[k];
        p8_q[k]   <= p7_q[k];
      end
      neg8_q <= neg7_q;
      dv8_q  <= dv7_q;
    end
  end

  // ---------------- side payload alongside the cell chains ----------------
  side_t side_q [ST_SQ0:ST_LAST];
  side_t side8;

  always_comb begin
    side8.pos = {p8_q[2], p8_q[1], p8_q[0]};
    side8.neg = neg8_q;
    side8.dv  = dv8_q;
    side8.mag = {mag8_q[2], mag8_q[1], mag8_q[0]};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[ST_SQ0] <= side8;
      for (int s = ST_SQ0 + 1; s <= ST_LAST; s++) side_q[s] <= side_q[s-1];
    end
  end

  // ---------------- root chain ----------------
  sq_t sq_c [NSQ+1];

  always_comb begin
    sq_c[0].n    = SQ_W'(sum8_q);
    sq_c[0].res  = '0;
    sq_c[0].bitv = SQ_W'(1) << (SQ_W - 2);
  end

  for (genvar i = 0; i < NSQ; i++) begin : g_sq
    cbz_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .sq_i  (sq_c[i]),
      .sq_o  (sq_c[i+1])
    );
  end

  // ---------------- divider set-up and lanes ----------------
  logic [L_W-1:0] len;
  dv_t            dp_q [3];
  dv_t            dv_c [3][ND+1];

  assign len = sq_c[NSQ].res[L_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dp_q[k].rem  <= {side_q[ST_DP-1].mag[k*MAG_W +: MAG_W], {(Q_W-1){1'b0}}}
                        + DV_W'(len >> 1);
        dp_q[k].dsor <= {len, {(Q_W-1){1'b0}}};
        dp_q[k].quo  <= '0;
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    assign dv_c[k][0] = dp_q[k];
    for (genvar i = 0; i < ND; i++) begin : g_div
      cbz_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .dv_i  (dv_c[k][i]),
        .dv_o  (dv_c[k][i+1])
      );
    end
  end

  // ---------------- result assembly ----------------
  res_t inc;
  always_comb begin
    logic [Q_W-1:0] q;
    logic [DW-1:0]  d;
    inc.pos = side_q[ST_LAST].pos;
    inc.dv  = side_q[ST_LAST].dv;
    for (int k = 0; k < 3; k++) begin
      q = dv_c[k][ND].quo;
      if (q > DIR_ONE) q = DIR_ONE;
      d = side_q[ST_LAST].neg[k] ? (DW'(0) - DW'(q)) : DW'(q);
      inc.dir[k*DW +: DW] = side_q[ST_LAST].dv ? d : '0;
    end
  end

  // ---------------- output register and skid ----------------
  res_t out_q, skid_q;
  logic out_v_q, skid_v_q;
  logic take, in_v;

  assign en   = !skid_v_q;
  assign take = out_v_q && m_axis_tready_i;
  assign in_v = v_q[ST_LAST] && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || take) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= in_v;
      end
    end else if (in_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || take) begin
      out_q <= skid_v_q ? skid_q : inc;
    end else if (in_v) begin
      skid_q <= inc;
    end
  end

  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {4'b0, out_q.dir, out_q.pos};
  assign m_axis_tuser_o  = out_q.dv;

  // ---------------- assertions ----------------
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled while output register empty");

  a_dir_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o[107:60] == '0))
    else $error("direction not zero without a tangent");

  a_dir_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[107:60] != '0))
    else $error("valid tangent with zero direction");

  a_skid_from_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(v_q[ST_LAST] && out_v_q && !m_axis_tready_i))
    else $error("skid filled without a stalled result");

endmodule
`default_nettype wire

// File: test/tb_cubic_bezier_point_and_tangent.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cubic_bezier_point_and_tangent
// Drives t values into the Bezier evaluator under several control point sets
// and idling phases, predicts point and unit tangent for every accepted item
// and compares each result item with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_cubic_bezier_point_and_tangent;
  import cbz_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN    = 80;

  typedef struct packed {
    logic [15:0] dz, dy, dx;
    logic [19:0] pz, py, px;
    logic        dv;
  } res_t;

  typedef struct {
    logic [16:0] t;
    logic        known;
    res_t        r;
  } row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [59:0]  cfg_data_i = '0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [23:0]  s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [111:0] m_axis_tdata_o;
  logic         m_axis_tuser_o;

  logic [59:0]  cp [4];
  res_t         curve_q [$];
  int           errors = 0;
  int           idle_cycles = 0;
  int           send_idle = 0;
  int           recv_stall = 0;
  bit           timed_out = 1'b0;

  cubic_bezier_point_and_tangent u_top (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // lerp of two coordinates, floor of the rounded product
  function automatic longint blend(longint a, longint b, longint t);
    longint p;
    p = (b - a) * t + (64'sd1 <<< (TF - 1));
    return a + (p >>> TF);
  endfunction

  function automatic longint isqrt(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // point and unit tangent at t for the current control points
  function automatic res_t eval_curve(logic [16:0] traw);
    longint a [4][3];
    longint b [3][3];
    longint e [2][3];
    longint p [3], v [3], mg [3], d [3];
    longint t, m, s, l, q;
    res_t r;
    t = (traw > T_ONE) ? longint'(T_ONE) : longint'(traw);
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 3; k++)
        a[i][k] = longint'($signed(cp[i][k*CW +: CW]));
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) b[i][k] = blend(a[i][k], a[i+1][k], t);
      for (int i = 0; i < 2; i++) e[i][k] = blend(b[i][k], b[i+1][k], t);
      p[k] = blend(e[0][k], e[1][k], t);
      v[k] = e[1][k] - p[k];
    end
    // fall back to the point near the end of the last segment
    if (v[0] == 0 && v[1] == 0 && v[2] == 0)
      for (int k = 0; k < 3; k++)
        v[k] = p[k] - blend(a[2][k], a[3][k], longint'(NEAR_T));
    r.dv = !(v[0] == 0 && v[1] == 0 && v[2] == 0);
    for (int k = 0; k < 3; k++) d[k] = 0;
    if (r.dv) begin
      m = 0;
      for (int k = 0; k < 3; k++) begin
        mg[k] = (v[k] < 0) ? -v[k] : v[k];
        if (mg[k] > m) m = mg[k];
      end
      while (m < (64'sd1 <<< 23)) begin
        m = m <<< 1;
        for (int k = 0; k < 3; k++) mg[k] = mg[k] <<< 1;
      end
      while (m >= (64'sd1 <<< 24)) begin
        m = m >>> 1;
        for (int k = 0; k < 3; k++) mg[k] = mg[k] >>> 1;
      end
      s = 0;
      for (int k = 0; k < 3; k++) s = s + mg[k] * mg[k];
      l = isqrt(s);
      for (int k = 0; k < 3; k++) begin
        q = ((mg[k] <<< 14) + (l >>> 1)) / l;
        if (q > 16384) q = 16384;
        d[k] = (v[k] < 0) ? -q : q;
      end
    end
    r.px = p[0][19:0];
    r.py = p[1][19:0];
    r.pz = p[2][19:0];
    r.dx = d[0][15:0];
    r.dy = d[1][15:0];
    r.dz = d[2][15:0];
    return r;
  endfunction

  // clock-edge sampled handshake bookkeeping and checks
  always @(posedge clk_i) begin
    res_t got, exp_r;
    bit acc;
    acc = 1'b0;
    if (s_axis_tvalid_i && s_axis_tready_o) acc = 1'b1;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      acc = 1'b1;
      got.px = m_axis_tdata_o[19:0];
      got.py = m_axis_tdata_o[39:20];
      got.pz = m_axis_tdata_o[59:40];
      got.dx = m_axis_tdata_o[75:60];
      got.dy = m_axis_tdata_o[91:76];
      got.dz = m_axis_tdata_o[107:92];
      got.dv = m_axis_tuser_o;
      if (curve_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item %h", got);
      end else begin
        exp_r = curve_q.pop_front();
        if (got !== exp_r) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp px %0d py %0d pz %0d dx %0d dy %0d dz %0d dv %0d",
                     $signed(exp_r.px), $signed(exp_r.py), $signed(exp_r.pz),
                     $signed(exp_r.dx), $signed(exp_r.dy), $signed(exp_r.dz), exp_r.dv,
                     "\n          got px %0d py %0d pz %0d dx %0d dy %0d dz %0d dv %0d",
                     $signed(got.px), $signed(got.py), $signed(got.pz),
                     $signed(got.dx), $signed(got.dy), $signed(got.dz), got.dv);
        end
      end
    end
    idle_cycles = acc ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1'b1;
      $display("tb_cubic_bezier_point_and_tangent: FAIL");
      $finish;
    end
  end

  // receiver: stall at the rate of the current phase
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall);
  end

  task automatic write_cp(logic [2:0] idx, logic [59:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx <= CFG_CP3) cp[idx[1:0]] = val;
  endtask

  // offer one t value, predict when it is offered; valid stays high for the next
  task automatic send_t(logic [16:0] t, bit known, res_t r);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'd0, t};
    curve_q.insert(curve_q.size(), known ? r : eval_curve(t));
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic drain_all();
    s_axis_tvalid_i <= 1'b0;
    while (curve_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  function automatic logic [59:0] rand_cp(int mode);
    logic [59:0] v;
    v = 60'({$urandom, $urandom});
    case (mode)
      0: v = v;
      1: for (int k = 0; k < 3; k++) v[k*CW +: CW] = 20'($signed(12'($urandom)));
      default: for (int k = 0; k < 3; k++)
        v[k*CW +: CW] = $urandom_range(1) ? 20'h7FFFF : 20'h80000;
    endcase
    return v;
  endfunction

  function automatic logic [16:0] rand_t();
    case ($urandom_range(9))
      0: return 17'($urandom_range(1 << 16, (1 << 17) - 1));
      1: return $urandom_range(1) ? 17'd0 : 17'h10000;
      default: return 17'($urandom_range(0, 1 << 16));
    endcase
  endfunction

  initial begin
    row_t dir_tab [$];
    res_t z;
    row_t rw;
    z = '0;
    for (int i = 0; i < 4; i++) cp[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all control points zero after reset: point zero, no tangent
    rw.known = 1'b1; rw.r = z;
    rw.t = 17'd0;       dir_tab.insert(dir_tab.size(), rw);
    rw.t = 17'h10000;   dir_tab.insert(dir_tab.size(), rw);
    rw.t = 17'h1FFFF;   dir_tab.insert(dir_tab.size(), rw);
    foreach (dir_tab[i]) send_t(dir_tab[i].t, dir_tab[i].known, dir_tab[i].r);
    drain_all();

    // extremes, straight line, a degenerate end and an ignored index
    write_cp(CFG_CP0, {3{20'h80000}});
    write_cp(CFG_CP1, {3{20'h7FFFF}});
    write_cp(CFG_CP2, {3{20'h80000}});
    write_cp(CFG_CP3, {3{20'h7FFFF}});
    write_cp(3'd5, '1);
    write_cp(3'd7, '1);
    dir_tab.delete();
    rw.known = 1'b0;
    for (int i = 0; i < 8; i++) begin
      rw.t = (i == 7) ? 17'h1ABCD : 17'(i * 9362);
      dir_tab.insert(dir_tab.size(), rw);
    end
    foreach (dir_tab[i]) send_t(dir_tab[i].t, 1'b0, z);
    drain_all();
    // last two points equal: tangent falls back near t equal to one
    write_cp(CFG_CP0, 60'd0);
    write_cp(CFG_CP1, {20'd0, 20'd0, 20'd2560});
    write_cp(CFG_CP2, {20'd0, 20'd256, 20'd0});
    write_cp(CFG_CP3, {20'd0, 20'd256, 20'd0});
    for (int i = 0; i < 6; i++) send_t((i < 3) ? 17'h10000 : 17'(65000 + i * 300), 1'b0, z);
    drain_all();

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 79; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 79; end
        default: begin send_idle = 10; recv_stall = 10; end
      endcase
      for (int i = 0; i < 4; i++) write_cp(3'(i), rand_cp(ph % 3));
      for (int n = 0; n < 71; n++) send_t(rand_t(), 1'b0, z);
      drain_all();
    end

    if (errors == 0) begin
      $display("tb_cubic_bezier_point_and_tangent: PASS");
    end else begin
      $display("tb_cubic_bezier_point_and_tangent: FAIL");
    end
    $finish;
  end

endmodule
